### rtl/core/qpg_pkg.sv
// Shared types for the projected gravity block.
// Used by the divider cell, the front end and the top level.
package qpg_pkg;

  // Flags that travel with one beat down the divider row.
  typedef struct packed {
    logic live;
    logic ok;
  } qpg_ctl_t;

endpackage

### rtl/core/qpg_div_cell.sv
// One restoring-division step for the three quotients of one beat.
// Depends on qpg_pkg for the control flags struct.
module qpg_div_cell
  import qpg_pkg::*;
#(
  parameter int NW = 66,
  parameter int QW = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  qpg_ctl_t          ctl_in,
  input  logic [NW-1:0]     den_in,
  input  logic [2:0][NW-1:0] rem_in,
  input  logic [2:0][QW-1:0] quo_in,
  input  logic [2:0]        neg_in,
  input  logic [2:0]        sat_in,
  output qpg_ctl_t          ctl_out,
  output logic [NW-1:0]     den_out,
  output logic [2:0][NW-1:0] rem_out,
  output logic [2:0][QW-1:0] quo_out,
  output logic [2:0]        neg_out,
  output logic [2:0]        sat_out
);

  logic [2:0][NW-1:0] rem_next;
  logic [2:0][QW-1:0] quo_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [NW-1:0] sh;
      sh = {rem_in[k][NW-2:0], 1'b0};
      if (sh >= den_in) begin
        rem_next[k] = sh - den_in;
        quo_next[k] = {quo_in[k][QW-2:0], 1'b1};
      end else begin
        rem_next[k] = sh;
        quo_next[k] = {quo_in[k][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    den_out <= den_in;
    rem_out <= rem_next;
    quo_out <= quo_next;
    neg_out <= neg_in;
    sat_out <= sat_in;
  end

endmodule

### rtl/core/quaternion_projected_gravity.sv
// Top level of the projected gravity block: front end, divider row, output stage.
// Depends on qpg_pkg and qpg_div_cell.
//
// Usage: pulse start with quat_x/y/z/w; a beat is taken whenever start is high
// (busy is tied low, so one beat per cycle is always accepted). Each beat makes
// exactly one result, shown for one cycle with done high, carrying gravity_x/y/z
// and result_valid. The path registers in order: products, sums, sign/magnitude
// set-up, one row cell per quotient bit (FRACTION_BITS + 1 cells), and one
// rounding register. Throughput is one beat per clock, set by the cell row:
// every cell holds a different beat and passes it to its neighbor each cycle.
// A quaternion whose squared norm is at or below min_norm_squared gives zeros
// with result_valid low. cfg_we writes min_norm_squared (reset 0).
// Synchronous reset clears the row's live flags, so no stray done follows
// reset. The receiver cannot stall; results are never held.
module quaternion_projected_gravity
  import qpg_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 16,
  parameter int FRACTION_BITS   = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_x,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_y,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_z,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_w,
  input  logic                              cfg_we,
  input  logic [31:0]                       cfg_data,
  output logic                              done,
  output logic signed [COMPONENT_WIDTH-1:0] gravity_x,
  output logic signed [COMPONENT_WIDTH-1:0] gravity_y,
  output logic signed [COMPONENT_WIDTH-1:0] gravity_z,
  output logic                              result_valid
);

  localparam int SHIFT = (COMPONENT_WIDTH > 31) ? COMPONENT_WIDTH - 31 : 0;
  localparam int WW    = COMPONENT_WIDTH - SHIFT;   // working component width
  localparam int PW    = 2 * WW;                    // one product
  localparam int NW    = PW + 3;                    // sums, doubled terms, shift room
  localparam int QW    = FRACTION_BITS + 1;         // quotient bits incl. round bit
  localparam int STEPS = FRACTION_BITS + 1;
  localparam logic [NW-1:0] LIMIT = NW'(1) << FRACTION_BITS;
  localparam logic [NW-1:0] MAXPOS = (NW'(1) << (COMPONENT_WIDTH - 1)) - NW'(1);

  logic [31:0] min_norm_squared;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_norm_squared <= '0;
    end else if (cfg_we) begin
      min_norm_squared <= cfg_data;
    end
  end

  // Stage 1: products.
  logic signed [WW-1:0] x, y, z, w;
  assign x = WW'(quat_x >>> SHIFT);
  assign y = WW'(quat_y >>> SHIFT);
  assign z = WW'(quat_z >>> SHIFT);
  assign w = WW'(quat_w >>> SHIFT);

  qpg_ctl_t s1_ctl, s2_ctl, s3_ctl;
  logic signed [PW-1:0] p_xx, p_yy, p_zz, p_ww, p_wy, p_xz, p_yz, p_wx;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl <= '{live: start, ok: 1'b0};
    end
    p_xx <= x * x;
    p_yy <= y * y;
    p_zz <= z * z;
    p_ww <= w * w;
    p_wy <= w * y;
    p_xz <= x * z;
    p_yz <= y * z;
    p_wx <= w * x;
  end

  // Stage 2: sums and threshold compare.
  logic [NW-1:0] n2;
  logic signed [NW-1:0] num_x, num_y, num_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else begin
      s2_ctl <= '{live: s1_ctl.live,
                  ok: (NW'(p_xx) + NW'(p_yy) + NW'(p_zz) + NW'(p_ww))
                      > NW'(min_norm_squared)};
    end
    n2    <= NW'(p_xx) + NW'(p_yy) + NW'(p_zz) + NW'(p_ww);
    num_x <= (NW'(p_wy) - NW'(p_xz)) <<< 1;
    num_y <= -((NW'(p_yz) + NW'(p_wx)) <<< 1);
    num_z <= (NW'(p_xx) + NW'(p_yy)) - (NW'(p_ww) + NW'(p_zz));
  end

  // Stage 3: sign and magnitude, saturation when |num| >= n2.
  logic [NW-1:0]        den_3;
  logic [2:0][NW-1:0]   rem_3;
  logic [2:0]           neg_3, sat_3;
  logic [2:0][NW-1:0]   mag_2;
  assign mag_2[0] = num_x[NW-1] ? NW'(-num_x) : NW'(num_x);
  assign mag_2[1] = num_y[NW-1] ? NW'(-num_y) : NW'(num_y);
  assign mag_2[2] = num_z[NW-1] ? NW'(-num_z) : NW'(num_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_ctl <= '0;
    end else begin
      s3_ctl <= s2_ctl;
    end
    den_3 <= n2;
    for (int k = 0; k < 3; k++) begin
      rem_3[k] <= (mag_2[k] >= n2) ? '0 : mag_2[k];
      sat_3[k] <= mag_2[k] >= n2;
    end
    neg_3 <= {num_z[NW-1], num_y[NW-1], num_x[NW-1]};
  end

  // Divider row: one quotient bit per cell.
  qpg_ctl_t                 c_ctl [STEPS+1];
  logic [NW-1:0]            c_den [STEPS+1];
  logic [2:0][NW-1:0]       c_rem [STEPS+1];
  logic [2:0][QW-1:0]       c_quo [STEPS+1];
  logic [2:0]               c_neg [STEPS+1];
  logic [2:0]               c_sat [STEPS+1];

  assign c_ctl[0] = s3_ctl;
  assign c_den[0] = den_3;
  assign c_rem[0] = rem_3;
  assign c_quo[0] = '0;
  assign c_neg[0] = neg_3;
  assign c_sat[0] = sat_3;

  for (genvar i = 0; i < STEPS; i++) begin : g_row
    qpg_div_cell #(.NW(NW), .QW(QW)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl_in (c_ctl[i]),
      .den_in (c_den[i]),
      .rem_in (c_rem[i]),
      .quo_in (c_quo[i]),
      .neg_in (c_neg[i]),
      .sat_in (c_sat[i]),
      .ctl_out(c_ctl[i+1]),
      .den_out(c_den[i+1]),
      .rem_out(c_rem[i+1]),
      .quo_out(c_quo[i+1]),
      .neg_out(c_neg[i+1]),
      .sat_out(c_sat[i+1])
    );
  end

  // Output stage: round half up on magnitude, clamp, apply sign; zeros for a rejected beat.
  logic [2:0][COMPONENT_WIDTH-1:0] g_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [NW-1:0] q;
      if (c_sat[STEPS][k]) begin
        q = LIMIT;
      end else begin
        q = (NW'(c_quo[STEPS][k]) + NW'(1)) >> 1;
      end
      if (q > LIMIT) q = LIMIT;
      if (q > MAXPOS) q = MAXPOS;
      if (c_neg[STEPS][k]) q = -q;
      g_next[k] = c_ctl[STEPS].ok ? COMPONENT_WIDTH'(q) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= c_ctl[STEPS].live;
    end
    gravity_x    <= g_next[0];
    gravity_y    <= g_next[1];
    gravity_z    <= g_next[2];
    result_valid <= c_ctl[STEPS].ok;
  end

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, FRACTION_BITS + 5))
    else $error("done without a matching start");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result_valid) |-> (gravity_x == '0 && gravity_y == '0 && gravity_z == '0))
    else $error("rejected beat with nonzero output");
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");

endmodule
